### design/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types, codes and helpers of the disjoint interval set.
// ----------------------------------------------------------------------------
`default_nettype none

package dis_pkg;

  // Default capacity of the interval list
  localparam int MAX_INTERVALS_DEF = 16;

  // Action codes
  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_REMOVE   = 3'd1;
  localparam logic [2:0] ACT_CONTAINS = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ABNORMAL = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  // One stored interval
  typedef struct packed {
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } entry_t;

  // One request as latched by the engine
  typedef struct packed {
    logic [2:0]         action;
    logic signed [63:0] start_time;
    logic signed [63:0] end_time;
    logic signed [63:0] query_time;
    logic [3:0]         entry_index;
  } req_t;

  // One result
  typedef struct packed {
    logic               hit;
    logic signed [63:0] entry_start;
    logic signed [63:0] entry_end;
    logic signed [63:0] earliest;
    logic signed [63:0] latest;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } res_t;

  // An interval ending at e_first touches one starting at s_second (65-bit compare)
  function automatic logic touches(input logic signed [63:0] e_first,
                                   input logic signed [63:0] s_second);
    logic signed [64:0] a;
    logic signed [64:0] b;
    a = {e_first[63], e_first};
    b = {s_second[63], s_second};
    return a >= (b - 65'sd1);
  endfunction

endpackage

`default_nettype wire

### design/dis_if.sv
// ----------------------------------------------------------------------------
// dis_in_if / dis_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dis_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [63:0] start_time;
  logic signed [63:0] end_time;
  logic signed [63:0] query_time;
  logic [3:0]         entry_index;

  modport source (output valid, action, start_time, end_time, query_time, entry_index,
                  input ready);
  modport sink (input valid, action, start_time, end_time, query_time, entry_index,
                output ready);
endinterface

interface dis_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [63:0] entry_start;
  logic signed [63:0] entry_end;
  logic signed [63:0] earliest;
  logic signed [63:0] latest;
  logic [4:0]         entry_count;
  logic [1:0]         status;

  modport source (output valid, hit, entry_start, entry_end, earliest, latest,
                  entry_count, status, input ready);
  modport sink (input valid, hit, entry_start, entry_end, earliest, latest,
                entry_count, status, output ready);
endinterface

`default_nettype wire

### design/dis_mem.sv
// ----------------------------------------------------------------------------
// dis_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_mem #(
  parameter int AW = 5
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire dis_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output dis_pkg::entry_t      rdata
);

  dis_pkg::entry_t mem [2**AW];
  dis_pkg::entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/dis_engine.sv
// ----------------------------------------------------------------------------
// dis_engine
// Request sequencer: walks the current bank of the entry store and, for add
// or remove, streams the new list into the other bank, then swaps on success.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_engine #(
  parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF,
  parameter int IDX_W         = $clog2(MAX_INTERVALS),
  parameter int AW            = IDX_W + 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire dis_pkg::req_t   req,
  output logic                 ready,
  output logic                 res_valid,
  input  wire logic            res_take,
  output dis_pkg::res_t        res,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output dis_pkg::entry_t      mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  wire dis_pkg::entry_t mem_rdata
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_CMT   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               bank_r, bank_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0]   wr_i_r, wr_i_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ins_r, ins_nxt;
  dis_pkg::req_t      req_r, req_nxt;
  logic signed [63:0] ns_r, ns_nxt;
  logic signed [63:0] ne_r, ne_nxt;
  logic               hit_r, hit_nxt;
  logic signed [63:0] rs_out_r, rs_out_nxt;
  logic signed [63:0] re_out_r, re_out_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [63:0] first_r, first_nxt;
  logic signed [63:0] last_r, last_nxt;
  logic signed [63:0] nfirst_r, nfirst_nxt;
  logic signed [63:0] nlast_r, nlast_nxt;

  logic               emit_v;
  logic signed [63:0] emit_s;
  logic signed [63:0] emit_e;
  logic               adv;
  logic [CNT_W-1:0]   rd_i_inc;
  logic signed [63:0] rs;
  logic signed [63:0] re;
  logic signed [63:0] s;
  logic signed [63:0] e;
  logic signed [63:0] t;
  logic [IDX_W+3:0]   idx_w;
  logic [CNT_W+3:0]   idx_ext;
  logic [CNT_W+3:0]   cnt_ext;
  logic [CNT_W+4:0]   cnt_out;

  assign rs       = mem_rdata.lo;
  assign re       = mem_rdata.hi;
  assign s        = req_r.start_time;
  assign e        = req_r.end_time;
  assign t        = req_r.query_time;
  assign rd_i_inc = rd_i_r + 1'b1;
  assign idx_w    = (IDX_W + 4)'(req_r.entry_index);
  assign idx_ext  = (CNT_W + 4)'(req.entry_index);
  assign cnt_ext  = (CNT_W + 4)'(cnt_r);

  // Sequence one request
  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    cnt_nxt    = cnt_r;
    rd_i_nxt   = rd_i_r;
    wr_i_nxt   = wr_i_r;
    ovf_nxt    = ovf_r;
    ins_nxt    = ins_r;
    req_nxt    = req_r;
    ns_nxt     = ns_r;
    ne_nxt     = ne_r;
    hit_nxt    = hit_r;
    rs_out_nxt = rs_out_r;
    re_out_nxt = re_out_r;
    status_nxt = status_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    nfirst_nxt = nfirst_r;
    nlast_nxt  = nlast_r;
    emit_v     = 1'b0;
    emit_s     = ns_r;
    emit_e     = ne_r;
    adv        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {~bank_r, wr_i_r[IDX_W-1:0]};
    mem_wdata  = '{lo: ns_r, hi: ne_r};
    mem_raddr  = {bank_r, rd_i_r[IDX_W-1:0]};
    if (req_r.action == dis_pkg::ACT_READ) begin
      mem_raddr = {bank_r, idx_w[IDX_W-1:0]};
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = req;
          hit_nxt    = 1'b0;
          rs_out_nxt = '0;
          re_out_nxt = '0;
          status_nxt = dis_pkg::STAT_OK;
          rd_i_nxt   = '0;
          wr_i_nxt   = '0;
          ovf_nxt    = 1'b0;
          ins_nxt    = 1'b0;
          ns_nxt     = req.start_time;
          ne_nxt     = req.end_time;
          case (req.action)
            dis_pkg::ACT_ADD, dis_pkg::ACT_REMOVE: begin
              if (req.start_time > req.end_time) begin
                status_nxt = dis_pkg::STAT_ABNORMAL;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = (cnt_r == '0) ? S_FLUSH : S_RD;
              end
            end
            dis_pkg::ACT_CONTAINS: state_nxt = (cnt_r == '0) ? S_FIN : S_RD;
            dis_pkg::ACT_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_FIN;
            end
            dis_pkg::ACT_READ: state_nxt = (idx_ext < cnt_ext) ? S_RD : S_FIN;
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_RD: state_nxt = S_PROC;

      S_PROC: begin
        case (req_r.action)
          dis_pkg::ACT_ADD: begin
            if (ins_r || !dis_pkg::touches(re, s)) begin
              emit_v = 1'b1; emit_s = rs; emit_e = re; adv = 1'b1;
            end else if (dis_pkg::touches(e, rs)) begin
              // merge touching entry into the pending interval
              if (rs < ns_r) ns_nxt = rs;
              if (re > ne_r) ne_nxt = re;
              adv = 1'b1;
            end else begin
              // place pending interval, then revisit this entry
              emit_v    = 1'b1;
              ins_nxt   = 1'b1;
              state_nxt = S_RD;
            end
          end
          dis_pkg::ACT_REMOVE: begin
            if (re < s || e < rs) begin
              emit_v = 1'b1; emit_s = rs; emit_e = re; adv = 1'b1;
            end else if (rs < s && e < re) begin
              // split: lower piece now, upper piece next cycle
              emit_v    = 1'b1; emit_s = rs; emit_e = s - 64'sd1;
              ns_nxt    = e + 64'sd1;
              ne_nxt    = re;
              state_nxt = S_SPLIT;
            end else if (rs < s) begin
              emit_v = 1'b1; emit_s = rs; emit_e = s - 64'sd1; adv = 1'b1;
            end else if (e < re) begin
              emit_v = 1'b1; emit_s = e + 64'sd1; emit_e = re; adv = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          dis_pkg::ACT_CONTAINS: begin
            if (rs <= t && t <= re) hit_nxt = 1'b1;
            adv = 1'b1;
          end
          dis_pkg::ACT_READ: begin
            rs_out_nxt = rs;
            re_out_nxt = re;
            state_nxt  = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end

      S_SPLIT: begin
        emit_v = 1'b1;
        adv    = 1'b1;
      end

      S_FLUSH: begin
        if (req_r.action == dis_pkg::ACT_ADD && !ins_r) emit_v = 1'b1;
        state_nxt = S_CMT;
      end

      S_CMT: begin
        if (req_r.action == dis_pkg::ACT_ADD || req_r.action == dis_pkg::ACT_REMOVE) begin
          if (ovf_r) begin
            status_nxt = dis_pkg::STAT_FULL;
          end else begin
            bank_nxt  = ~bank_r;
            cnt_nxt   = wr_i_r;
            first_nxt = nfirst_r;
            last_nxt  = nlast_r;
          end
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (res_take) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Advance to the next stored entry
    if (adv) begin
      rd_i_nxt  = rd_i_inc;
      state_nxt = (rd_i_inc == cnt_r) ? S_FLUSH : S_RD;
    end

    // Write one entry of the new list into the other bank, or flag overflow when full
    if (emit_v) begin
      if (wr_i_r == MAX_CNT) begin
        ovf_nxt = 1'b1;
      end else begin
        mem_we    = 1'b1;
        mem_wdata = '{lo: emit_s, hi: emit_e};
        wr_i_nxt  = wr_i_r + 1'b1;
        if (wr_i_r == '0) nfirst_nxt = emit_s;
        nlast_nxt = emit_e;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    rd_i_r   <= rd_i_nxt;
    wr_i_r   <= wr_i_nxt;
    ovf_r    <= ovf_nxt;
    ins_r    <= ins_nxt;
    req_r    <= req_nxt;
    ns_r     <= ns_nxt;
    ne_r     <= ne_nxt;
    hit_r    <= hit_nxt;
    rs_out_r <= rs_out_nxt;
    re_out_r <= re_out_nxt;
    status_r <= status_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    nfirst_r <= nfirst_nxt;
    nlast_r  <= nlast_nxt;
  end

  // Result
  assign cnt_out   = (CNT_W + 5)'(cnt_r);
  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.hit         = hit_r;
  assign res.entry_start = rs_out_r;
  assign res.entry_end   = re_out_r;
  assign res.earliest    = (cnt_r != '0) ? first_r : 64'sd0;
  assign res.latest      = (cnt_r != '0) ? last_r : 64'sd0;
  assign res.entry_count = cnt_out[4:0];
  assign res.status      = status_r;

endmodule

`default_nettype wire

### design/disjoint_interval_set_core.sv
// ----------------------------------------------------------------------------
// disjoint_interval_set_core
// Sorted list of disjoint inclusive intervals with add, remove, contains,
// clear and read requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, remove and contains walk the stored
// list through a single memory read port with registered read data, reading
// each stored entry and then processing it. An add that places its interval
// before a later entry reads that entry once more, and a remove that splits
// an entry writes its upper piece in a state of its own. The updated list
// is streamed into the second bank of the store and the banks swap only on
// success, so a rejected request leaves the list as it was. Clear, abnormal
// intervals, out-of-range reads and a contains on an empty list skip the
// walk, and an in-range read reads a single entry. A finished result sits in
// an output register, and the next request is taken as soon as the result
// has moved into it.
`default_nettype none

module disjoint_interval_set_core #(
  parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dis_in_if.sink   in_ch,
  dis_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int AW    = IDX_W + 1;

  dis_pkg::req_t   req;
  dis_pkg::res_t   res;
  dis_pkg::res_t   out_data_r;
  logic            out_valid_r;
  logic            eng_ready;
  logic            res_valid;
  logic            res_take;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  dis_pkg::entry_t mem_wdata;
  dis_pkg::entry_t mem_rdata;

  assign req.action      = in_ch.action;
  assign req.start_time  = in_ch.start_time;
  assign req.end_time    = in_ch.end_time;
  assign req.query_time  = in_ch.query_time;
  assign req.entry_index = in_ch.entry_index;
  assign in_ch.ready     = eng_ready;

  dis_engine #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .IDX_W        (IDX_W),
    .AW           (AW)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_ch.valid && eng_ready),
    .req      (req),
    .ready    (eng_ready),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  dis_mem #(
    .AW(AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Move a finished result into the output register when it is free or being taken
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_data_r.hit;
  assign out_ch.entry_start = out_data_r.entry_start;
  assign out_ch.entry_end   = out_data_r.entry_end;
  assign out_ch.earliest    = out_data_r.earliest;
  assign out_ch.latest      = out_data_r.latest;
  assign out_ch.entry_count = out_data_r.entry_count;
  assign out_ch.status      = out_data_r.status;

endmodule

`default_nettype wire

### design/dis_checker.sv
// ----------------------------------------------------------------------------
// dis_checker
// Port-level checks of the interval set core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [63:0] out_entry_start,
  input wire logic [4:0]  out_entry_count,
  input wire logic [1:0]  out_status
);

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dis_pkg::STAT_OK || out_status == dis_pkg::STAT_ABNORMAL ||
                   out_status == dis_pkg::STAT_FULL))
    else $error("undefined status code");

  // A hit only comes with an ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == dis_pkg::STAT_OK))
    else $error("hit with non-ok status");

  // One request in flight: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_entry_start) &&
                                   $stable(out_entry_count) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind disjoint_interval_set_core dis_checker u_dis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_entry_start(out_ch.entry_start),
  .out_entry_count(out_ch.entry_count),
  .out_status     (out_ch.status)
);

`default_nettype wire

### sim/disjoint_interval_set_core_test.sv
// ----------------------------------------------------------------------------
// disjoint_interval_set_core_test
// Self-checking bench for the disjoint interval set core: a directed table of
// requests and random, partly malformed traffic, checked against a local
// model of the sorted interval list, with random gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_interval_set_core_test;

  localparam int CAP = 16;
  localparam int RANDOM_REQS = 650;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [63:0] TMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] TMAX = 64'sh7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dis_in_if  in_ch ();
  dis_out_if out_ch ();

  disjoint_interval_set_core #(.MAX_INTERVALS(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the interval list
  logic signed [63:0] set_lo [CAP+1];
  logic signed [63:0] set_hi [CAP+1];
  int set_count;

  dis_pkg::res_t pending_results [$];
  int   failures;
  longint cycle_count;

  function automatic bit adjoins(logic signed [63:0] e_first, logic signed [63:0] s_second);
    logic signed [64:0] a;
    logic signed [64:0] b;
    a = {e_first[63], e_first};
    b = {s_second[63], s_second};
    return a >= b - 65'sd1;
  endfunction

  function automatic logic [1:0] merge_interval(logic signed [63:0] s, logic signed [63:0] e);
    int lo;
    int hi;
    int removed;
    int newcount;
    logic signed [63:0] ns;
    logic signed [63:0] ne;
    lo = 0;
    ns = s;
    ne = e;
    while (lo < set_count && !adjoins(set_hi[lo], s)) lo++;
    hi = lo;
    while (hi < set_count && adjoins(e, set_lo[hi])) hi++;
    removed = hi - lo;
    newcount = set_count - removed + 1;
    if (newcount > CAP) return dis_pkg::STAT_FULL;
    if (removed > 0) begin
      if (set_lo[lo] < ns) ns = set_lo[lo];
      if (set_hi[hi-1] > ne) ne = set_hi[hi-1];
      for (int k = 0; lo + 1 + k < newcount; k++) begin
        set_lo[lo+1+k] = set_lo[hi+k];
        set_hi[lo+1+k] = set_hi[hi+k];
      end
    end else begin
      for (int k = set_count; k > lo; k--) begin
        set_lo[k] = set_lo[k-1];
        set_hi[k] = set_hi[k-1];
      end
    end
    set_lo[lo] = ns;
    set_hi[lo] = ne;
    set_count = newcount;
    return dis_pkg::STAT_OK;
  endfunction

  function automatic logic [1:0] cut_interval(logic signed [63:0] s, logic signed [63:0] e);
    int i;
    logic signed [63:0] rs;
    logic signed [63:0] re;
    i = 0;
    while (i < set_count) begin
      rs = set_lo[i];
      re = set_hi[i];
      if (re < s) begin
        i++;
      end else if (e < rs) begin
        break;
      end else if (rs < s && e < re) begin
        if (set_count >= CAP) return dis_pkg::STAT_FULL;
        for (int k = set_count; k > i + 1; k--) begin
          set_lo[k] = set_lo[k-1];
          set_hi[k] = set_hi[k-1];
        end
        set_hi[i] = s - 1;
        set_lo[i+1] = e + 1;
        set_hi[i+1] = re;
        set_count++;
        break;
      end else if (rs < s) begin
        set_hi[i] = s - 1;
        i++;
      end else if (e < re) begin
        set_lo[i] = e + 1;
        break;
      end else begin
        for (int k = i; k + 1 < set_count; k++) begin
          set_lo[k] = set_lo[k+1];
          set_hi[k] = set_hi[k+1];
        end
        set_count--;
      end
    end
    return dis_pkg::STAT_OK;
  endfunction

  // Apply one request to the local list and return the expected result
  function automatic dis_pkg::res_t apply_request(dis_pkg::req_t r);
    dis_pkg::res_t y;
    y = '0;
    case (r.action)
      dis_pkg::ACT_ADD, dis_pkg::ACT_REMOVE: begin
        if (r.start_time > r.end_time) y.status = dis_pkg::STAT_ABNORMAL;
        else if (r.action == dis_pkg::ACT_ADD)
          y.status = merge_interval(r.start_time, r.end_time);
        else y.status = cut_interval(r.start_time, r.end_time);
      end
      dis_pkg::ACT_CONTAINS: begin
        for (int k = 0; k < set_count; k++)
          if (set_lo[k] <= r.query_time && r.query_time <= set_hi[k]) y.hit = 1'b1;
      end
      dis_pkg::ACT_CLEAR: set_count = 0;
      dis_pkg::ACT_READ: begin
        if (r.entry_index < set_count) begin
          y.entry_start = set_lo[r.entry_index];
          y.entry_end = set_hi[r.entry_index];
        end
      end
      default: ;
    endcase
    if (set_count > 0) begin
      y.earliest = set_lo[0];
      y.latest = set_hi[set_count-1];
    end
    y.entry_count = 5'(set_count);
    return y;
  endfunction

  // Send one request, waiting for acceptance; inputs move on the falling edge
  task automatic send_request(dis_pkg::req_t r);
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.action;
    in_ch.start_time  <= r.start_time;
    in_ch.end_time    <= r.end_time;
    in_ch.query_time  <= r.query_time;
    in_ch.entry_index <= r.entry_index;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [63:0] rand_time();
    case ($urandom_range(0, 9))
      0: return TMIN + $urandom_range(0, 3);
      1: return TMAX - $urandom_range(0, 3);
      2: return {$urandom, $urandom};
      default: return 64'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic dis_pkg::req_t rand_request();
    dis_pkg::req_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    int pick;
    r = '0;
    pick = $urandom_range(0, 99);
    a = rand_time();
    b = ($urandom_range(0, 9) < 8) ? a + 64'($urandom_range(0, 30)) : rand_time();
    if (b < a && $urandom_range(0, 3) != 0) begin
      r.start_time = b;
      r.end_time = a;
    end else begin
      r.start_time = a;
      r.end_time = b;
    end
    if (r.start_time > r.end_time && $urandom_range(0, 1)) r.end_time = r.start_time;
    r.query_time = rand_time();
    r.entry_index = 4'($urandom_range(0, 15));
    if (pick < 40) r.action = dis_pkg::ACT_ADD;
    else if (pick < 62) r.action = dis_pkg::ACT_REMOVE;
    else if (pick < 80) r.action = dis_pkg::ACT_CONTAINS;
    else if (pick < 83) r.action = dis_pkg::ACT_CLEAR;
    else if (pick < 97) r.action = dis_pkg::ACT_READ;
    else r.action = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // Directed table: action, start, end, query, index, typed result, check flag
  typedef struct {
    dis_pkg::req_t r;
    dis_pkg::res_t y;
    bit   typed;
  } row_t;

  function automatic row_t mk(logic [2:0] act, logic signed [63:0] s, logic signed [63:0] e,
                              logic signed [63:0] q, logic [3:0] idx);
    row_t w;
    w.r.action = act;
    w.r.start_time = s;
    w.r.end_time = e;
    w.r.query_time = q;
    w.r.entry_index = idx;
    w.y = '0;
    w.typed = 1'b0;
    return w;
  endfunction

  // Output stall pattern of its own
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (cycle_count % 500 < 120) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 9) < 6);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    dis_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.hit !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, out_ch.hit); failures++;
        end
        if (out_ch.entry_start !== want.entry_start) begin
          $error("entry_start expected %0d got %0d", want.entry_start, out_ch.entry_start);
          failures++;
        end
        if (out_ch.entry_end !== want.entry_end) begin
          $error("entry_end expected %0d got %0d", want.entry_end, out_ch.entry_end);
          failures++;
        end
        if (out_ch.earliest !== want.earliest) begin
          $error("earliest expected %0d got %0d", want.earliest, out_ch.earliest); failures++;
        end
        if (out_ch.latest !== want.latest) begin
          $error("latest expected %0d got %0d", want.latest, out_ch.latest); failures++;
        end
        if (out_ch.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d got %0d", want.entry_count, out_ch.entry_count);
          failures++;
        end
        if (out_ch.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_ch.status); failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t w;
    dis_pkg::res_t y;
    int burst;
    failures = 0;
    cycle_count = 0;
    set_count = 0;
    in_ch.valid = 1'b0;
    in_ch.action = dis_pkg::ACT_CONTAINS;
    in_ch.start_time = '0;
    in_ch.end_time = '0;
    in_ch.query_time = '0;
    in_ch.entry_index = '0;

    // Reads and queries after reset see an empty list
    w = mk(dis_pkg::ACT_READ, 0, 0, 0, 0); w.typed = 1; rows.push_back(w);
    w = mk(dis_pkg::ACT_CONTAINS, 0, 0, TMIN, 0); w.typed = 1; rows.push_back(w);
    // Abnormal intervals are ignored
    w = mk(dis_pkg::ACT_ADD, 5, 4, 0, 0); w.typed = 1; w.y.status = dis_pkg::STAT_ABNORMAL;
    rows.push_back(w);
    w = mk(dis_pkg::ACT_REMOVE, TMAX, TMIN, 0, 0); w.typed = 1;
    w.y.status = dis_pkg::STAT_ABNORMAL;
    rows.push_back(w);
    // Extremes: whole range, then cuts in the middle and at both ends
    w = mk(dis_pkg::ACT_ADD, TMIN, TMAX, 0, 0); w.typed = 1; w.y.earliest = TMIN;
    w.y.latest = TMAX; w.y.entry_count = 1; rows.push_back(w);
    rows.push_back(mk(dis_pkg::ACT_CONTAINS, 0, 0, TMAX, 0));
    rows.push_back(mk(dis_pkg::ACT_REMOVE, -10, 10, 0, 0));
    rows.push_back(mk(dis_pkg::ACT_REMOVE, TMIN, TMIN, 0, 0));
    rows.push_back(mk(dis_pkg::ACT_REMOVE, TMAX, TMAX, 0, 0));
    rows.push_back(mk(dis_pkg::ACT_READ, 0, 0, 0, 1));
    rows.push_back(mk(dis_pkg::ACT_READ, 0, 0, 0, 15));
    // Adjacency at the minimum time
    rows.push_back(mk(dis_pkg::ACT_ADD, TMIN, TMIN, 0, 0));
    rows.push_back(mk(dis_pkg::ACT_ADD, 11, TMAX, 0, 0));
    w = mk(dis_pkg::ACT_CLEAR, 0, 0, 0, 0); w.typed = 1; rows.push_back(w);
    // Unused action codes
    w = mk(3'd7, 1, 2, 3, 4); w.typed = 1; rows.push_back(w);
    foreach (rows[i]) begin
      y = apply_request(rows[i].r);
      if (rows[i].typed && y !== rows[i].y) begin
        $error("directed row %0d disagrees with typed result", i); failures++;
      end
      pending_results.push_back(rows[i].typed ? rows[i].y : y);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_request(rows[i].r);

    // Fill to capacity with isolated short intervals, then overflow on add and on split
    for (int k = 0; k < 18; k++) begin
      w = mk(dis_pkg::ACT_ADD, 64'(k * 10), 64'(k * 10 + 2), 0, 0);
      pending_results.push_back(apply_request(w.r));
      send_request(w.r);
    end
    w = mk(dis_pkg::ACT_REMOVE, 21, 21, 0, 0);
    pending_results.push_back(apply_request(w.r));
    send_request(w.r);

    // Random bursts with random gaps
    for (int n = 0; n < RANDOM_REQS; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        w.r = rand_request();
        pending_results.push_back(apply_request(w.r));
        send_request(w.r);
      end
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
    drop_valid();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### disjoint_interval_set_core.f
design/dis_pkg.sv
design/dis_if.sv
design/dis_mem.sv
design/dis_engine.sv
design/disjoint_interval_set_core.sv
design/dis_checker.sv
sim/disjoint_interval_set_core_test.sv
